@@ design/sbs_pkg.sv @@
// shared constants, widths and controller/datapath interface types for the burst splitter
// no dependencies
package sbs_pkg;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 10;
    localparam int WADDR_W = ADDR_W - 2;
    localparam int CHUNK_W = 9;
    localparam int CMD_W   = 8;
    localparam int DUMMY_W = 5;
    localparam int WSEL_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 9;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    localparam int MAX_REQUEST_BYTES = 1020;

    localparam logic [CHUNK_W-1:0] MAX_CHUNK_LOW  = CHUNK_W'(64);
    localparam logic [CHUNK_W-1:0] MAX_CHUNK_HIGH = CHUNK_W'(256);
    localparam logic [CMD_W-1:0]   WRITE_BASE_CMD = 8'h80;
    localparam logic [CMD_W-1:0]   READ_BASE_CMD  = 8'h60;

    localparam logic [CIDX_W-1:0] CFG_MAX_CHUNK = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WAIT_SEL  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_LANE_MODE = 2'd2;

    localparam logic [CHUNK_W-1:0] RST_MAX_CHUNK = CHUNK_W'(256);
    localparam logic [WSEL_W-1:0]  RST_WAIT_SEL  = 2'd2;
    localparam logic               RST_LANE_MODE = 1'b0;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic emit_chunk;
        logic emit_error;
    } t_ctrl_cmd;

    typedef struct packed {
        logic len_zero;
        logic len_bad;
        logic last_chunk;
        logic out_free;
    } t_ctrl_stat;

endpackage

@@ design/sbs_ctrl.sv @@
// request sequencer for the burst splitter: idle, chunk run, error result
// depends on sbs_pkg
module sbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  sbs_pkg::t_ctrl_stat i_stat,
    output sbs_pkg::t_ctrl_cmd  o_cmd
);
    import sbs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        o_cmd.in_ready   = (r_state == ST_IDLE);
        o_cmd.load       = o_cmd.in_ready && i_in_valid;
        o_cmd.emit_chunk = (r_state == ST_RUN) && i_stat.out_free;
        o_cmd.emit_error = (r_state == ST_ERR) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    priority if (i_stat.len_zero) n_state = ST_IDLE;
                    else if (i_stat.len_bad)      n_state = ST_ERR;
                    else                          n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_cmd.emit_chunk && i_stat.last_chunk) n_state = ST_IDLE;
            end
            ST_ERR: begin
                if (o_cmd.emit_error) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/sbs_dp.sv @@
// datapath for the burst splitter: remainder, address and offset registers,
// chunk sizing, command lookup and the output register; depends on sbs_pkg
module sbs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbs_pkg::t_ctrl_cmd            i_cmd,
    output sbs_pkg::t_ctrl_stat           o_stat,
    input  logic                          i_mode,
    input  logic [sbs_pkg::ADDR_W-1:0]    i_byte_address,
    input  logic [sbs_pkg::LEN_W-1:0]     i_byte_length,
    input  logic [sbs_pkg::CHUNK_W-1:0]   i_max_chunk,
    input  logic [sbs_pkg::WSEL_W-1:0]    i_wait_sel,
    input  logic                          i_lane_mode,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [sbs_pkg::CMD_W-1:0]     o_command,
    output logic [sbs_pkg::WADDR_W-1:0]   o_word_address,
    output logic [sbs_pkg::DUMMY_W-1:0]   o_dummy_bytes,
    output logic [sbs_pkg::CHUNK_W-1:0]   o_chunk_bytes,
    output logic [sbs_pkg::LEN_W-1:0]     o_byte_offset,
    output logic                          o_is_write,
    output logic                          o_length_error,
    output logic                          o_last
);
    import sbs_pkg::*;

    function automatic logic [CHUNK_W-1:0] eff_max(input logic [CHUNK_W-1:0] v);
        logic [CHUNK_W-1:0] m;
        m = {v[CHUNK_W-1:2], 2'b00};
        if (m < MAX_CHUNK_LOW)  m = MAX_CHUNK_LOW;
        if (m > MAX_CHUNK_HIGH) m = MAX_CHUNK_HIGH;
        return m;
    endfunction

    function automatic logic [CMD_W-1:0] chunk_cmd(input logic [CHUNK_W-1:0] c,
                                                   input logic [CMD_W-1:0] base);
        logic [CMD_W-1:0] cmd;
        unique case (c)
            CHUNK_W'(4):   cmd = base + CMD_W'(0);
            CHUNK_W'(16):  cmd = base + CMD_W'(1);
            CHUNK_W'(32):  cmd = base + CMD_W'(2);
            CHUNK_W'(64):  cmd = base + CMD_W'(3);
            CHUNK_W'(128): cmd = base + CMD_W'(4);
            CHUNK_W'(256): cmd = base + CMD_W'(5);
            default:       cmd = '0;
        endcase
        return cmd;
    endfunction

    logic                r_is_wr;
    logic [WADDR_W-1:0]  r_waddr;
    logic [LEN_W-1:0]    r_rem;
    logic [LEN_W-1:0]    r_offset;
    logic [CHUNK_W-1:0]  r_maxc;
    logic [CMD_W-1:0]    r_base;
    logic [DUMMY_W-1:0]  r_dummy;
    logic                r_out_valid;
    logic                n_out_valid;

    logic [LEN_W-1:0]    low_bit;
    logic [CHUNK_W-1:0]  chunk;
    logic [2:0]          wait_mult;
    logic [DUMMY_W-1:0]  dummy_calc;
    logic [CMD_W-1:0]    read_base;

    assign wait_mult  = {1'b0, i_wait_sel} + 3'd1;
    assign dummy_calc = i_lane_mode ? DUMMY_W'({wait_mult, 2'b00})
                                    : DUMMY_W'({wait_mult, 1'b0});
    assign read_base  = READ_BASE_CMD + CMD_W'({i_wait_sel, 3'b000});

    assign low_bit = r_rem & (~r_rem + LEN_W'(1));

    always_comb begin
        if (r_rem >= LEN_W'(r_maxc)) begin
            chunk = r_maxc;
        end else if (low_bit == LEN_W'(8)) begin
            chunk = CHUNK_W'(4);
        end else begin
            chunk = low_bit[CHUNK_W-1:0];
        end
    end

    always_comb begin
        o_stat.len_zero   = (i_byte_length == '0);
        o_stat.len_bad    = (i_byte_length[1:0] != 2'b00) ||
                            (i_byte_length > LEN_W'(MAX_REQUEST_BYTES));
        o_stat.last_chunk = (r_rem == LEN_W'(chunk));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_wr  <= i_mode;
            r_waddr  <= i_byte_address[ADDR_W-1:2];
            r_rem    <= i_byte_length;
            r_offset <= '0;
            r_maxc   <= eff_max(i_max_chunk);
            r_base   <= i_mode ? WRITE_BASE_CMD : read_base;
            r_dummy  <= i_mode ? '0 : dummy_calc;
        end else if (i_cmd.emit_chunk) begin
            r_rem    <= r_rem - LEN_W'(chunk);
            r_offset <= r_offset + LEN_W'(chunk);
            r_waddr  <= r_waddr + WADDR_W'(chunk[CHUNK_W-1:2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_chunk) begin
            o_command      <= chunk_cmd(chunk, r_base);
            o_word_address <= r_waddr;
            o_dummy_bytes  <= r_dummy;
            o_chunk_bytes  <= chunk;
            o_byte_offset  <= r_offset;
            o_is_write     <= r_is_wr;
            o_length_error <= 1'b0;
            o_last         <= o_stat.last_chunk;
        end else if (i_cmd.emit_error) begin
            o_command      <= '0;
            o_word_address <= '0;
            o_dummy_bytes  <= '0;
            o_chunk_bytes  <= '0;
            o_byte_offset  <= '0;
            o_is_write     <= r_is_wr;
            o_length_error <= 1'b1;
            o_last         <= 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit_chunk || i_cmd.emit_error) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/spi_bridge_burst_splitter.sv @@
// top level of the spi bridge burst splitter: config registers, sequencer and datapath
// depends on sbs_pkg, sbs_ctrl and sbs_dp
// an accepted request is first loaded into the datapath registers; its first descriptor
// is then registered into the output register. throughput: one descriptor per cycle while
// the output is taken; a new request is accepted only after the last chunk or the error
// result of the previous one is emitted, and a zero-length request gives no descriptor
// reset: synchronous active low, empties the output register, config back to defaults
module spi_bridge_burst_splitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // byte_address [31:0], byte_length [41:32], zero pad [47:42]
    input  logic [sbs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // mode [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // command [7:0], word_address [37:8], dummy_bytes [42:38], chunk_bytes [51:43],
    // byte_offset [61:52], zero pad [63:62]
    output logic [sbs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // is_write [0], length_error [1]
    output logic [sbs_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sbs_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [sbs_pkg::CDAT_W-1:0]        i_cfg_data
);
    import sbs_pkg::*;

    logic [CHUNK_W-1:0] r_max_chunk;
    logic [WSEL_W-1:0]  r_wait_sel;
    logic               r_lane_mode;

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    logic [CMD_W-1:0]   command;
    logic [WADDR_W-1:0] word_address;
    logic [DUMMY_W-1:0] dummy_bytes;
    logic [CHUNK_W-1:0] chunk_bytes;
    logic [LEN_W-1:0]   byte_offset;
    logic               is_write;
    logic               length_error;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chunk <= RST_MAX_CHUNK;
            r_wait_sel  <= RST_WAIT_SEL;
            r_lane_mode <= RST_LANE_MODE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_CHUNK: r_max_chunk <= i_cfg_data[CHUNK_W-1:0];
                CFG_WAIT_SEL:  r_wait_sel  <= i_cfg_data[WSEL_W-1:0];
                CFG_LANE_MODE: r_lane_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sbs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (s_axis_tuser),
        .i_byte_address (s_axis_tdata[ADDR_W-1:0]),
        .i_byte_length  (s_axis_tdata[ADDR_W+LEN_W-1:ADDR_W]),
        .i_max_chunk    (r_max_chunk),
        .i_wait_sel     (r_wait_sel),
        .i_lane_mode    (r_lane_mode),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_command      (command),
        .o_word_address (word_address),
        .o_dummy_bytes  (dummy_bytes),
        .o_chunk_bytes  (chunk_bytes),
        .o_byte_offset  (byte_offset),
        .o_is_write     (is_write),
        .o_length_error (length_error),
        .o_last         (m_axis_tlast)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {2'b00, byte_offset, chunk_bytes, dummy_bytes, word_address, command};
    assign m_axis_tuser  = {length_error, is_write};

`ifndef NO_ASSERTIONS
    // a chunk result never moves zero bytes
    a_chunk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !length_error) |-> (chunk_bytes != '0))
        else $error("zero byte chunk");

    // error result is always the final result of its request
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && length_error) |-> (m_axis_tlast && chunk_bytes == '0))
        else $error("error result without last");

    // writes carry no dummy bytes
    a_wr_dummy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && is_write) |-> (dummy_bytes == '0))
        else $error("write with dummy bytes");

    // a new result is only produced when the output slot can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !(cmd.emit_chunk || cmd.emit_error))
        else $error("output overwritten");
`endif

endmodule
